@@ rtl/tlt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlt_pkg
// Types, token kinds, scan modes and character classes of the tokenizer.
// ----------------------------------------------------------------------------
package tlt_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} tlt_in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] token_value;
		logic [15:0] line_number;
		logic        last_of_run;
	} tlt_out_t;

	// symbol table request: name byte writes into the scratch slot, search start
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_pos;
		logic [7:0] wr_ch;
		logic       start;
		logic [8:0] len;
	} tlt_symreq_t;

	typedef struct packed {
		logic        done;
		logic        ok;
		logic [31:0] index;
	} tlt_symrsp_t;

	typedef struct packed {
		logic       emit;
		logic [4:0] kind;
		logic [2:0] mode;
		logic       newline;
	} tlt_sc_t;

	localparam logic [4:0] K_LBRACE = 5'd5;
	localparam logic [4:0] K_RBRACE = 5'd6;
	localparam logic [4:0] K_LPAREN = 5'd7;
	localparam logic [4:0] K_RPAREN = 5'd8;
	localparam logic [4:0] K_PLUS   = 5'd9;
	localparam logic [4:0] K_MINUS  = 5'd10;
	localparam logic [4:0] K_LESS   = 5'd11;
	localparam logic [4:0] K_SEMI   = 5'd12;
	localparam logic [4:0] K_ASSIGN = 5'd13;
	localparam logic [4:0] K_NUM    = 5'd14;
	localparam logic [4:0] K_ID     = 5'd15;
	localparam logic [4:0] K_CALL   = 5'd16;
	localparam logic [4:0] K_END    = 5'd17;
	localparam logic [4:0] K_EQEQ   = 5'd18;
	localparam logic [4:0] K_STAR   = 5'd19;
	localparam logic [4:0] K_SLASH  = 5'd20;
	localparam logic [4:0] K_LBRACK = 5'd21;
	localparam logic [4:0] K_RBRACK = 5'd22;
	localparam logic [4:0] K_ERR    = 5'd23;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_NUM  = 3'd1;
	localparam logic [2:0] M_NAME = 3'd2;
	localparam logic [2:0] M_EQ   = 3'd3;
	localparam logic [2:0] M_DONE = 3'd4;
	localparam logic [2:0] M_ERR  = 3'd5;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam int KW_COUNT = 5;
	localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
		'{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h75, 8'h6E, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd4, 4'd2, 4'd5, 4'd8};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_name_more(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_LOWER_Z) || c == CH_UNDER;
	endfunction

	// decode a byte seen with no token pending
	function automatic tlt_sc_t tlt_start(input logic [7:0] c);
		tlt_sc_t r;
		r = '0;
		r.mode = M_IDLE;
		r.kind = K_ERR;
		case (c)
			CH_NL:     r.newline = 1'b1;
			CH_SPACE,
			CH_TAB:    r.emit = 1'b0;
			CH_LBRACE: begin r.emit = 1'b1; r.kind = K_LBRACE; end
			CH_RBRACE: begin r.emit = 1'b1; r.kind = K_RBRACE; end
			CH_LPAREN: begin r.emit = 1'b1; r.kind = K_LPAREN; end
			CH_RPAREN: begin r.emit = 1'b1; r.kind = K_RPAREN; end
			CH_PLUS:   begin r.emit = 1'b1; r.kind = K_PLUS; end
			CH_MINUS:  begin r.emit = 1'b1; r.kind = K_MINUS; end
			CH_LESS:   begin r.emit = 1'b1; r.kind = K_LESS; end
			CH_SEMI:   begin r.emit = 1'b1; r.kind = K_SEMI; end
			CH_STAR:   begin r.emit = 1'b1; r.kind = K_STAR; end
			CH_SLASH:  begin r.emit = 1'b1; r.kind = K_SLASH; end
			CH_LBRACK: begin r.emit = 1'b1; r.kind = K_LBRACK; end
			CH_RBRACK: begin r.emit = 1'b1; r.kind = K_RBRACK; end
			CH_EQ:     r.mode = M_EQ;
			default: begin
				if (is_digit(c)) begin
					r.mode = M_NUM;
				end else if (c >= CH_UPPER_A && c <= CH_LOWER_Z) begin
					r.mode = M_NAME;
				end else begin
					r.emit = 1'b1;
					r.mode = M_ERR;
				end
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/tiny_language_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tiny_language_tokenizer
// Byte-at-a-time tokenizer with keyword detection and symbol interning.
// ----------------------------------------------------------------------------
// Input channel char_valid/char_stall/char_item carries one source byte or
// the end-of-input mark per transaction. Output channel tok_valid/tok_stall/
// tok_item carries tokens; each input transaction yields zero to two tokens,
// the last flagged with last_of_run.
// Most bytes are decoded in the cycle they are taken and their tokens are
// offered from the next cycle; a byte that yields no token frees the input
// again on the next cycle.
// A byte that ends an identifier that is not a keyword starts a symbol search:
// each stored entry has its length read and checked (SS_LEN, SS_LCK), an entry
// of equal length then has its bytes compared one by one (SS_CH, SS_CCK), and
// the token is delivered through T_WAIT and T_TAIL, so the search time grows
// with the number of stored symbols and, where lengths match, with the name.
// A new transaction is taken once all tokens of the previous one have been
// taken; a stalled receiver therefore holds the input side too.
// Reset returns to line 1 with an empty symbol table; no clearing pass.
// After an error token or the end token, all input is consumed silently.
// ----------------------------------------------------------------------------
module tiny_language_tokenizer import tlt_pkg::*; #(
	parameter int MAX_SYMBOLS    = 64,
	parameter int MAX_NAME_CHARS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_stall,
	input  tlt_in_t  char_item,
	output logic     tok_valid,
	input  logic     tok_stall,
	output tlt_out_t tok_item
);

	localparam int LW = $clog2(MAX_NAME_CHARS + 1);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_WAIT = 2'd1;
	localparam logic [1:0] T_TAIL = 2'd2;

	logic [1:0]    st_q, st_d;
	logic [2:0]    mode_q, mode_d;
	logic [31:0]   acc_q, acc_d;
	logic [LW-1:0] len_q, len_d;
	logic [15:0]   line_q;
	logic [7:0]    kw_q [8];
	logic [7:0]    c_q;
	logic          eoi_q;
	tlt_out_t      res_q [2];
	logic [1:0]    rcnt_q;
	logic [1:0]    rptr_q;

	tlt_symreq_t req;
	tlt_symrsp_t rsp;

	logic        take;
	logic        line_inc;
	logic        e0v, e1v;
	logic [4:0]  e0k, e1k;
	logic [31:0] e0d, e1d;
	logic        sc_apply;
	logic        sc_slot;
	tlt_sc_t     sc;
	logic [7:0]  sc_ch;
	logic        kw_hit;
	logic [2:0]  kw_idx;
	logic [31:0] acc_next;
	logic [1:0]  base;
	logic [1:0]  rptr_inc;

	tlt_symtab #(
		.MAX_SYMBOLS    (MAX_SYMBOLS),
		.MAX_NAME_CHARS (MAX_NAME_CHARS)
	) u_symtab (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign char_stall = !(st_q == T_IDLE && rptr_q == rcnt_q);
	assign take       = char_valid && !char_stall;
	assign tok_valid  = st_q == T_IDLE && rptr_q != rcnt_q;
	assign acc_next   = (acc_q << 3) + (acc_q << 1) + {28'd0, char_item.char_code[3:0]};
	assign base       = take ? 2'd0 : rcnt_q;
	assign rptr_inc   = rptr_q + 2'd1;

	always_comb begin
		tok_item             = res_q[rptr_q[0]];
		tok_item.last_of_run = rptr_inc == rcnt_q;
	end

	always_comb begin
		logic m;
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			m = len_q == LW'(KW_LEN[k]);
			for (int p = 0; p < 8; p++) begin
				if (p < int'(KW_LEN[k]) && kw_q[p] != KW_TEXT[k][p]) begin
					m = 1'b0;
				end
			end
			if (m) begin
				kw_hit = 1'b1;
				kw_idx = 3'(k);
			end
		end
	end

	always_comb begin
		e0v = 1'b0; e1v = 1'b0;
		e0k = K_ERR; e1k = K_ERR;
		e0d = '0; e1d = '0;
		st_d = st_q; mode_d = mode_q; acc_d = acc_q; len_d = len_q;
		line_inc = 1'b0;
		req = '0;
		sc_apply = 1'b0; sc_slot = 1'b0;
		sc = tlt_start(char_item.char_code);
		sc_ch = char_item.char_code;
		unique case (st_q)
			T_IDLE: begin
				if (take && mode_q != M_ERR && mode_q != M_DONE) begin
					if (char_item.end_of_input) begin
						if (mode_q == M_NAME && !kw_hit) begin
							req.start = 1'b1;
							req.len   = 9'(len_q);
							st_d      = T_WAIT;
						end else begin
							e0v = 1'b1; e0k = K_END; mode_d = M_DONE;
							if (mode_q == M_NUM || mode_q == M_EQ || mode_q == M_NAME) begin
								e1v = 1'b1; e1k = K_END;
								e0k = (mode_q == M_NUM) ? K_NUM :
									(mode_q == M_EQ) ? K_ASSIGN : 5'(kw_idx);
								e0d = (mode_q == M_NUM) ? acc_q : '0;
							end
						end
					end else if (mode_q == M_NUM) begin
						if (is_digit(char_item.char_code)) begin
							acc_d = acc_next;
						end else begin
							e0v = 1'b1; e0k = K_NUM; e0d = acc_q;
							sc_apply = 1'b1; sc_slot = 1'b1;
						end
					end else if (mode_q == M_NAME) begin
						if (is_name_more(char_item.char_code)) begin
							if (len_q >= LW'(MAX_NAME_CHARS)) begin
								e0v = 1'b1; e0k = K_ERR; mode_d = M_ERR;
							end else begin
								req.wr_en  = 1'b1;
								req.wr_pos = 8'(len_q);
								req.wr_ch  = char_item.char_code;
								len_d      = len_q + LW'(1);
							end
						end else if (kw_hit) begin
							e0v = 1'b1; e0k = 5'(kw_idx);
							sc_apply = 1'b1; sc_slot = 1'b1;
						end else begin
							req.start = 1'b1;
							req.len   = 9'(len_q);
							st_d      = T_WAIT;
						end
					end else if (mode_q == M_EQ) begin
						if (char_item.char_code == CH_EQ) begin
							e0v = 1'b1; e0k = K_EQEQ; mode_d = M_IDLE;
						end else begin
							e0v = 1'b1; e0k = K_ASSIGN;
							sc_apply = 1'b1; sc_slot = 1'b1;
						end
					end else begin
						sc_apply = 1'b1;
					end
				end
			end
			T_WAIT: begin
				if (rsp.done) begin
					e0v = 1'b1;
					if (!rsp.ok) begin
						e0k = K_ERR; mode_d = M_ERR; st_d = T_IDLE;
					end else begin
						e0k = (!eoi_q && c_q == CH_LPAREN) ? K_CALL : K_ID;
						e0d = rsp.index;
						st_d = T_TAIL;
					end
				end
			end
			T_TAIL: begin
				st_d = T_IDLE;
				if (eoi_q) begin
					e0v = 1'b1; e0k = K_END; mode_d = M_DONE;
				end else begin
					sc = tlt_start(c_q);
					sc_ch = c_q;
					sc_apply = 1'b1;
				end
			end
			default: st_d = T_IDLE;
		endcase
		if (sc_apply) begin
			mode_d   = sc.mode;
			line_inc = sc.newline;
			if (sc.emit) begin
				if (sc_slot) begin
					e1v = 1'b1; e1k = sc.kind;
				end else begin
					e0v = 1'b1; e0k = sc.kind;
				end
			end
			if (sc.mode == M_NUM) begin
				acc_d = {28'd0, sc_ch[3:0]};
			end
			if (sc.mode == M_NAME) begin
				req.wr_en  = 1'b1;
				req.wr_pos = '0;
				req.wr_ch  = sc_ch;
				len_d      = LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			c_q   <= char_item.char_code;
			eoi_q <= char_item.end_of_input;
		end
		if (req.wr_en && req.wr_pos < 8'd8) begin
			kw_q[req.wr_pos[2:0]] <= req.wr_ch;
		end
		if (e0v) begin
			res_q[base[0]] <= '{token_kind: e0k, token_value: e0d,
				line_number: line_q, last_of_run: 1'b0};
		end
		if (e1v) begin
			res_q[base[0] ^ e0v] <= '{token_kind: e1k, token_value: e1d,
				line_number: line_q, last_of_run: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= T_IDLE;
			mode_q <= M_IDLE;
			acc_q  <= '0;
			len_q  <= '0;
			line_q <= 16'd1;
			rcnt_q <= '0;
			rptr_q <= '0;
		end else begin
			st_q   <= st_d;
			mode_q <= mode_d;
			acc_q  <= acc_d;
			len_q  <= len_d;
			if (line_inc && line_q != 16'hFFFF) begin
				line_q <= line_q + 16'd1;
			end
			rcnt_q <= base + 2'(e0v) + 2'(e1v);
			if (take) begin
				rptr_q <= '0;
			end else if (tok_valid && !tok_stall) begin
				rptr_q <= rptr_inc;
			end
		end
	end

	a_no_tokens_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		take && mode_q == M_ERR |=> rcnt_q == 2'd0)
		else $error("tokens produced after error");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q != 2'd3 && rptr_q <= rcnt_q)
		else $error("result run count out of range");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0)
		else $error("line counter reached zero");

endmodule

@@ rtl/tlt_symtab.sv @@
// ----------------------------------------------------------------------------
// tlt_symtab
// Symbol table: name bytes and lengths in memories, sequential search and
// insertion. The name being scanned is built in the scratch slot.
// ----------------------------------------------------------------------------
module tlt_symtab import tlt_pkg::*; #(
	parameter int MAX_SYMBOLS    = 64,
	parameter int MAX_NAME_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tlt_symreq_t req,
	output tlt_symrsp_t rsp
);

	localparam int SW = $clog2(MAX_SYMBOLS + 1);
	localparam int IW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_NAME_CHARS);
	localparam int LW = $clog2(MAX_NAME_CHARS + 1);
	localparam int AW = SW + CW;
	localparam int DEPTH = 1 << AW;

	localparam logic [2:0] SS_IDLE = 3'd0;
	localparam logic [2:0] SS_LEN  = 3'd1;
	localparam logic [2:0] SS_LCK  = 3'd2;
	localparam logic [2:0] SS_CH   = 3'd3;
	localparam logic [2:0] SS_CCK  = 3'd4;

	logic [7:0]    name_mem [DEPTH];
	logic [LW-1:0] len_mem [MAX_SYMBOLS];

	logic [2:0]    st_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] next_q;
	logic [CW-1:0] pos_q;
	logic [LW-1:0] want_q;
	logic [LW-1:0] len_rd_q;
	logic [7:0]    cha_q;
	logic [7:0]    chb_q;
	tlt_symrsp_t   rsp_q;
	logic          at_end;
	logic          room;
	logic          commit;

	assign at_end = idx_q == next_q;
	assign room   = next_q != SW'(MAX_SYMBOLS);
	assign commit = st_q == SS_LEN && at_end && room;
	assign rsp    = rsp_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			name_mem[{next_q, req.wr_pos[CW-1:0]}] <= req.wr_ch;
		end
		if (commit) begin
			len_mem[next_q[IW-1:0]] <= want_q;
		end
		cha_q    <= name_mem[{idx_q, pos_q}];
		chb_q    <= name_mem[{next_q, pos_q}];
		len_rd_q <= len_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SS_IDLE;
			idx_q  <= '0;
			next_q <= '0;
			pos_q  <= '0;
			want_q <= '0;
			rsp_q  <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (st_q)
				SS_IDLE: begin
					if (req.start) begin
						want_q <= req.len[LW-1:0];
						idx_q  <= '0;
						st_q   <= SS_LEN;
					end
				end
				SS_LEN: begin
					if (at_end) begin
						rsp_q.done  <= 1'b1;
						rsp_q.ok    <= room;
						rsp_q.index <= 32'(next_q);
						if (room) begin
							next_q <= next_q + SW'(1);
						end
						st_q <= SS_IDLE;
					end else begin
						st_q <= SS_LCK;
					end
				end
				SS_LCK: begin
					if (len_rd_q == want_q) begin
						pos_q <= '0;
						st_q  <= SS_CH;
					end else begin
						idx_q <= idx_q + SW'(1);
						st_q  <= SS_LEN;
					end
				end
				SS_CH: st_q <= SS_CCK;
				SS_CCK: begin
					if (cha_q != chb_q) begin
						idx_q <= idx_q + SW'(1);
						st_q  <= SS_LEN;
					end else if (LW'(pos_q) + LW'(1) == want_q) begin
						rsp_q.done  <= 1'b1;
						rsp_q.ok    <= 1'b1;
						rsp_q.index <= 32'(idx_q);
						st_q        <= SS_IDLE;
					end else begin
						pos_q <= pos_q + CW'(1);
						st_q  <= SS_CH;
					end
				end
				default: st_q <= SS_IDLE;
			endcase
		end
	end

endmodule

@@ dv/tiny_language_tokenizer_check.sv @@
// ----------------------------------------------------------------------------
// tiny_language_tokenizer_check
// Watches both channels of the tokenizer, predicts the token stream from the
// accepted source bytes and compares every accepted token field by field.
// ----------------------------------------------------------------------------
module tiny_language_tokenizer_check import tlt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	input  logic     char_stall,
	input  tlt_in_t  char_item,
	input  logic     tok_valid,
	input  logic     tok_stall,
	input  tlt_out_t tok_item,
	output int       errors,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYMS     = 64;
	localparam int NAME_MAX = 64;

	logic [2:0]  mode;
	logic [31:0] acc;
	logic [7:0]  name_text [NAME_MAX];
	int          name_len;
	logic [15:0] line;
	logic [7:0]  sym_text [SYMS][NAME_MAX];
	int          sym_len [SYMS];
	int          sym_count;

	tlt_out_t run_toks [2];
	int       run_n;
	tlt_out_t tokens_due [$];

	function automatic void put_token(logic [4:0] kind, logic [31:0] value);
		if (run_n < 2) begin
			run_toks[run_n] = '{token_kind: kind, token_value: value,
				line_number: line, last_of_run: 1'b0};
			run_n++;
		end
	endfunction

	function automatic void raise_error();
		put_token(K_ERR, 32'd0);
		mode = M_ERR;
	endfunction

	function automatic bit close_name(bit call);
		bit same;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (int'(KW_LEN[k]) == name_len) begin
				same = 1'b1;
				for (int j = 0; j < name_len; j++)
					if (KW_TEXT[k][j] != name_text[j]) same = 1'b0;
				if (same) begin
					put_token(5'(k), 32'd0);
					return 1'b1;
				end
			end
		end
		for (int i = 0; i < SYMS; i++) begin
			if (sym_len[i] == name_len) begin
				same = 1'b1;
				for (int j = 0; j < name_len; j++)
					if (sym_text[i][j] != name_text[j]) same = 1'b0;
				if (same) begin
					put_token(call ? K_CALL : K_ID, 32'(i));
					return 1'b1;
				end
			end
		end
		if (sym_count >= SYMS) return 1'b0;
		for (int j = 0; j < name_len; j++) sym_text[sym_count][j] = name_text[j];
		sym_len[sym_count] = name_len;
		put_token(call ? K_CALL : K_ID, 32'(sym_count));
		sym_count++;
		return 1'b1;
	endfunction

	function automatic void open_char(logic [7:0] c);
		case (c)
			CH_NL:     if (line != 16'hFFFF) line++;
			CH_SPACE,
			CH_TAB:    ;
			CH_LBRACE: put_token(K_LBRACE, 32'd0);
			CH_RBRACE: put_token(K_RBRACE, 32'd0);
			CH_LPAREN: put_token(K_LPAREN, 32'd0);
			CH_RPAREN: put_token(K_RPAREN, 32'd0);
			CH_PLUS:   put_token(K_PLUS, 32'd0);
			CH_MINUS:  put_token(K_MINUS, 32'd0);
			CH_LESS:   put_token(K_LESS, 32'd0);
			CH_SEMI:   put_token(K_SEMI, 32'd0);
			CH_STAR:   put_token(K_STAR, 32'd0);
			CH_SLASH:  put_token(K_SLASH, 32'd0);
			CH_LBRACK: put_token(K_LBRACK, 32'd0);
			CH_RBRACK: put_token(K_RBRACK, 32'd0);
			CH_EQ:     mode = M_EQ;
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					acc = 32'(c - CH_ZERO);
					mode = M_NUM;
				end else if (c >= CH_UPPER_A && c <= CH_LOWER_Z) begin
					name_text[0] = c;
					name_len = 1;
					mode = M_NAME;
				end else begin
					raise_error();
				end
			end
		endcase
	endfunction

	function automatic void predict(tlt_in_t it);
		logic [7:0] c;
		c = it.char_code;
		run_n = 0;
		if (mode == M_DONE || mode == M_ERR) return;
		if (it.end_of_input) begin
			if (mode == M_NUM) put_token(K_NUM, acc);
			else if (mode == M_NAME) begin
				if (!close_name(1'b0)) raise_error();
			end else if (mode == M_EQ) put_token(K_ASSIGN, 32'd0);
			if (mode != M_ERR) begin
				put_token(K_END, 32'd0);
				mode = M_DONE;
			end
		end else if (mode == M_NUM) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				acc = acc * 32'd10 + 32'(c - CH_ZERO);
			end else begin
				put_token(K_NUM, acc);
				mode = M_IDLE;
				open_char(c);
			end
		end else if (mode == M_NAME) begin
			if ((c >= CH_UPPER_A && c <= CH_LOWER_Z) || c == CH_UNDER) begin
				if (name_len >= NAME_MAX) raise_error();
				else begin
					name_text[name_len] = c;
					name_len++;
				end
			end else if (!close_name(c == CH_LPAREN)) begin
				raise_error();
			end else begin
				mode = M_IDLE;
				open_char(c);
			end
		end else if (mode == M_EQ) begin
			mode = M_IDLE;
			if (c == CH_EQ) put_token(K_EQEQ, 32'd0);
			else begin
				put_token(K_ASSIGN, 32'd0);
				open_char(c);
			end
		end else begin
			mode = M_IDLE;
			open_char(c);
		end
		if (run_n > 0) run_toks[run_n - 1].last_of_run = 1'b1;
		for (int i = 0; i < run_n; i++) tokens_due.push_back(run_toks[i]);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tlt_out_t want;
		if (!arst_n) begin
			mode = M_IDLE;
			acc = '0;
			name_len = 0;
			line = 16'd1;
			sym_count = 0;
			for (int i = 0; i < SYMS; i++) sym_len[i] = 0;
			tokens_due.delete();
			errors = 0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tokens_due.size() == 0) begin
					report("unexpected token kind", 32'(tok_item.token_kind), 32'd0);
				end else begin
					want = tokens_due.pop_front();
					if (tok_item.token_kind != want.token_kind)
						report("token_kind", 32'(tok_item.token_kind), 32'(want.token_kind));
					if (tok_item.token_value != want.token_value)
						report("token_value", tok_item.token_value, want.token_value);
					if (tok_item.line_number != want.line_number)
						report("line_number", 32'(tok_item.line_number),
							32'(want.line_number));
					if (tok_item.last_of_run != want.last_of_run)
						report("last_of_run", 32'(tok_item.last_of_run),
							32'(want.last_of_run));
				end
			end
			if (char_valid && !char_stall) predict(char_item);
		end
		pending = tokens_due.size();
	end

endmodule

@@ dv/tiny_language_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// tiny_language_tokenizer_test
// Drives source text into the tokenizer: a directed passage, a long random
// program built from a pool of names and one randomly chosen way of ending
// (end mark, illegal byte, overlong name or full symbol table), then ignored
// traffic. Both channels idle at random; a checker beside the block predicts
// and compares.
// ----------------------------------------------------------------------------
module tiny_language_tokenizer_test;
	import tlt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT     = 40000;
	localparam int POOL_SIZE = 60;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     char_valid = 1'b0;
	logic     char_stall;
	tlt_in_t  char_item = '0;
	logic     tok_valid;
	logic     tok_stall = 1'b0;
	tlt_out_t tok_item;
	int       errors;
	int       pending;

	bit         calm = 1'b0;
	bit         hold_long = 1'b0;
	int         sent = 0;
	int         quiet = 0;
	logic [7:0] pool [POOL_SIZE][64];
	int         pool_len [POOL_SIZE];

	tiny_language_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_item(tok_item)
	);

	tiny_language_tokenizer_check i_check (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_item(tok_item),
		.errors(errors), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (tok_valid && !tok_stall)) begin
			quiet <= 0;
		end else if (quiet + 1 >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_long) begin
				tok_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
			end else begin
				n = gap_len();
				if (n > 0) begin
					tok_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				tok_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(tlt_in_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			char_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_item('{char_code: c, end_of_input: 1'b0});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_char(s.getc(i));
	endtask

	task automatic send_sep();
		string seps;
		seps = " ( \n;)+-\t";
		send_char(seps.getc($urandom_range(0, seps.len() - 1)));
	endtask

	task automatic send_word();
		int p, k;
		if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, KW_COUNT - 1);
			for (int j = 0; j < int'(KW_LEN[k]); j++) send_char(KW_TEXT[k][j]);
		end else begin
			p = $urandom_range(0, POOL_SIZE - 1);
			for (int j = 0; j < pool_len[p]; j++) send_char(pool[p][j]);
		end
		send_sep();
	endtask

	initial begin
		int start, kind, ends;
		logic [7:0] c;
		string punct;
		punct = "{}()+-<;*/[]";
		for (int p = 0; p < POOL_SIZE; p++) begin
			pool_len[p] = (p == 0) ? 64 : ($urandom_range(0, 9) == 0) ?
				$urandom_range(9, 40) : $urandom_range(1, 8);
			pool[p][0] = 8'($urandom_range(8'h61, 8'h79));
			for (int j = 1; j < pool_len[p]; j++)
				pool[p][j] = 8'($urandom_range(CH_UPPER_A, CH_LOWER_Z));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("do else if while function {}()+-<;*/[] = == =x ");
		send_text("0 4294967295 99999999999 abc abc( abc\n\t^q_[x]`r ]");

		start = sent;
		while (sent - start < 900) begin
			if (sent - start > 300 && sent - start < 310) hold_long = 1'b1;
			if (sent - start > 600 && sent - start < 606) begin
				char_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			calm = (sent - start) % 400 > 340;
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: send_word();
				4: begin
					repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(CH_ZERO, CH_NINE)));
					send_sep();
				end
				5, 6: send_char(punct.getc($urandom_range(0, punct.len() - 1)));
				7: send_text($urandom_range(0, 1) ? "=" : "==");
				default: send_sep();
			endcase
		end

		calm = 1'b0;
		send_text("x;");

		ends = $urandom_range(0, 3);
		case (ends)
			0: begin
				case ($urandom_range(0, 3))
					0: send_text("12");
					1: send_text(" ab");
					2: send_text("=");
					default: ;
				endcase
				send_item('{char_code: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
			end
			1: begin
				if ($urandom_range(0, 1)) send_text("77");
				do c = 8'($urandom_range(0, 255));
				while ((c >= CH_UPPER_A && c <= CH_LOWER_Z) || (c >= CH_ZERO && c <= CH_NINE) ||
					c == CH_NL || c == CH_TAB || c == CH_SPACE || c == CH_EQ ||
					c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
					c == CH_RPAREN || c == CH_PLUS || c == CH_MINUS || c == CH_LESS ||
					c == CH_SEMI || c == CH_STAR || c == CH_SLASH);
				send_char(c);
			end
			2: begin
				send_char(CH_SPACE);
				repeat (65) send_char(8'h71);
				send_char(CH_SPACE);
			end
			default: begin
				for (int f = 0; f < 70; f++) begin
					send_char(8'h5A);
					send_char(8'(CH_UPPER_A + f % 26));
					send_char(8'(CH_UPPER_A + f / 26));
					send_char($urandom_range(0, 1) ? CH_LPAREN : CH_SPACE);
				end
			end
		endcase

		repeat (40)
			send_item('{char_code: 8'($urandom_range(0, 255)),
				end_of_input: 1'($urandom_range(0, 1))});
		char_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
